### sv/tri_ang_pkg.sv
`timescale 1ns / 1ps
package tri_ang_pkg;

  // Fixed-point constants, radians in Q2.30.
  localparam logic [31:0] PI_Q30      = 32'd3373259426;
  localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;
  localparam logic [30:0] ONE_Q30     = 31'd1073741824;

  // Step counts of the iterative units.
  localparam int INT_STEPS    = 3;
  localparam int FRAC_STEPS   = 30;
  localparam int DIV_STEPS    = INT_STEPS + FRAC_STEPS;
  localparam int SQRT_STEPS   = 31;
  localparam int CORDIC_STEPS = 30;

  // Stage counts of the two lane units.
  localparam int COS_LAT  = 3 + DIV_STEPS + 1;
  localparam int ACOS_LAT = 2 + SQRT_STEPS + CORDIC_STEPS + 1;
  localparam int LANE_LAT = COS_LAT + ACOS_LAT;

  // Width of the CORDIC datapath.
  localparam int CW = 34;

  // Status that travels with an item between the cosine and arccosine units.
  typedef struct packed {
    logic vld;
    logic en;
  } stage_ctl_t;

  // Angle table atan(2^-i) in Q2.30.
  function automatic logic signed [CW-1:0] atan_q30(input logic [4:0] i);
    logic signed [CW-1:0] v;
    case (i)
      5'd0:  v = 34'sh3243F6A8;
      5'd1:  v = 34'sh1DAC6705;
      5'd2:  v = 34'sh0FADBAFC;
      5'd3:  v = 34'sh07F56EA6;
      5'd4:  v = 34'sh03FEAB76;
      5'd5:  v = 34'sh01FFD55B;
      5'd6:  v = 34'sh00FFFAAA;
      5'd7:  v = 34'sh007FFF55;
      5'd8:  v = 34'sh003FFFEA;
      5'd9:  v = 34'sh001FFFFD;
      5'd10: v = 34'sh000FFFFF;
      5'd11: v = 34'sh0007FFFF;
      5'd12: v = 34'sh0003FFFF;
      5'd13: v = 34'sh0001FFFF;
      5'd14: v = 34'sh0000FFFF;
      5'd15: v = 34'sh00007FFF;
      5'd16: v = 34'sh00003FFF;
      5'd17: v = 34'sh00001FFF;
      5'd18: v = 34'sh00000FFF;
      5'd19: v = 34'sh000007FF;
      5'd20: v = 34'sh000003FF;
      5'd21: v = 34'sh000001FF;
      5'd22: v = 34'sh000000FF;
      5'd23: v = 34'sh0000007F;
      5'd24: v = 34'sh0000003F;
      5'd25: v = 34'sh0000001F;
      5'd26: v = 34'sh0000000F;
      5'd27: v = 34'sh00000008;
      5'd28: v = 34'sh00000004;
      5'd29: v = 34'sh00000002;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

### sv/triangle_angles_from_sides.sv
`timescale 1ns / 1ps
// Triangle interior angles from three side lengths.
// Input channel: in_valid / in_ready with the sides in_side_ab, in_side_bc,
// in_side_ca as unsigned Q16.16. Output channel: out_valid / out_ready with
// the angles opposite each side in radians, unsigned Q2.30, and
// out_bad_triangle, which is set (angles zero) when a side is zero or the
// triangle inequality fails.
// Throughput is one item per cycle while the output is not stalled. Every
// stage of the three angle lanes advances together; the iterative stages
// give one quotient bit, root bit or CORDIC rotation each. An item passes
// 37 stages for the products and the long division to the cosine, 64 for
// the square root and CORDIC arccosine, and the output register before out_valid.
// Synchronous reset clears every valid bit, so the pipeline comes up empty.
// When out_ready is low with a result waiting, the whole pipeline holds and
// in_ready drops; nothing is lost or repeated, and flow resumes in the cycle
// that the waiting result is taken.
module triangle_angles_from_sides (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_side_ab,
  input  logic [31:0] in_side_bc,
  input  logic [31:0] in_side_ca,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_angle_opp_ab,
  output logic [31:0] out_angle_opp_bc,
  output logic [31:0] out_angle_opp_ca,
  output logic        out_bad_triangle
);

  localparam int LL = tri_ang_pkg::LANE_LAT;

  // Global advance: the pipeline moves whenever the output slot is free or being emptied.
  logic                    en;
  logic                    out_valid_r;
  tri_ang_pkg::stage_ctl_t ctl;

  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;
  assign ctl.vld  = in_valid;
  assign ctl.en   = en;

  // Rejection test on the raw sides.
  logic [32:0] sum_bc, sum_ac, sum_ab;
  logic        bad_nxt;

  always_comb begin
    sum_bc  = {1'b0, in_side_bc} + {1'b0, in_side_ca};
    sum_ac  = {1'b0, in_side_ab} + {1'b0, in_side_ca};
    sum_ab  = {1'b0, in_side_ab} + {1'b0, in_side_bc};
    bad_nxt = (in_side_ab == 32'd0) || (in_side_bc == 32'd0) || (in_side_ca == 32'd0) ||
              ({1'b0, in_side_ab} > sum_bc) || ({1'b0, in_side_bc} > sum_ac) ||
              ({1'b0, in_side_ca} > sum_ab);
  end

  // The rejection flag follows its item down a delay line of lane length.
  logic bd_r [LL];

  for (genvar k = 0; k < LL; k++) begin : g_bad
    if (k == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (en) bd_r[k] <= bad_nxt;
      end
    end else begin : g_next
      always_ff @(posedge clk) begin
        if (en) bd_r[k] <= bd_r[k-1];
      end
    end
  end

  // One lane per angle, sides rotated so the first is always the opposite one.
  logic        vld_ab, vld_bc, vld_ca;
  logic [31:0] ang_ab, ang_bc, ang_ca;

  tri_ang_lane u_lane_ab (
    .clk (clk), .rst_n (rst_n), .ctl_in (ctl),
    .side_opp (in_side_ab), .side_b (in_side_bc), .side_c (in_side_ca),
    .out_vld (vld_ab), .angle (ang_ab)
  );

  tri_ang_lane u_lane_bc (
    .clk (clk), .rst_n (rst_n), .ctl_in (ctl),
    .side_opp (in_side_bc), .side_b (in_side_ab), .side_c (in_side_ca),
    .out_vld (vld_bc), .angle (ang_bc)
  );

  tri_ang_lane u_lane_ca (
    .clk (clk), .rst_n (rst_n), .ctl_in (ctl),
    .side_opp (in_side_ca), .side_b (in_side_ab), .side_c (in_side_bc),
    .out_vld (vld_ca), .angle (ang_ca)
  );

  // Output register: rejected items read zero angles.
  logic [31:0] ang_ab_r, ang_bc_r, ang_ca_r;
  logic        bad_r;

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (en) out_valid_r <= vld_ab;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      bad_r    <= bd_r[LL-1];
      ang_ab_r <= bd_r[LL-1] ? 32'd0 : ang_ab;
      ang_bc_r <= bd_r[LL-1] ? 32'd0 : ang_bc;
      ang_ca_r <= bd_r[LL-1] ? 32'd0 : ang_ca;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_angle_opp_ab = ang_ab_r;
  assign out_angle_opp_bc = ang_bc_r;
  assign out_angle_opp_ca = ang_ca_r;
  assign out_bad_triangle = bad_r;

  // The three lanes must carry the same items in lockstep.
  a_lane_sync: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_ab == vld_bc) && (vld_ab == vld_ca))
    else $error("angle lanes out of step");

  // A rejected item shows zero angles.
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_bad_triangle) |->
      (out_angle_opp_ab == 32'd0) && (out_angle_opp_bc == 32'd0) &&
      (out_angle_opp_ca == 32'd0))
    else $error("rejected item with nonzero angle");

  // Every angle stays within [0, pi].
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_angle_opp_ab <= tri_ang_pkg::PI_Q30) &&
      (out_angle_opp_bc <= tri_ang_pkg::PI_Q30) &&
      (out_angle_opp_ca <= tri_ang_pkg::PI_Q30))
    else $error("angle beyond pi");

  // A stalled result holds out_angle_opp_ab and out_bad_triangle until taken.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid && $stable(out_angle_opp_ab) &&
      $stable(out_bad_triangle))
    else $error("stalled result changed");

endmodule

### sv/tri_ang_cos.sv
`timescale 1ns / 1ps
module tri_ang_cos (
  input  logic                      clk,
  input  logic                      rst_n,
  input  tri_ang_pkg::stage_ctl_t   ctl_in,
  input  logic [31:0]               side_opp,
  input  logic [31:0]               side_b,
  input  logic [31:0]               side_c,
  output logic                      out_vld,
  output logic signed [31:0]        cos_q30
);

  localparam int DS = tri_ang_pkg::DIV_STEPS;
  localparam int IS = tri_ang_pkg::INT_STEPS;

  logic en;
  assign en = ctl_in.en;

  // Stage 1: difference of the adjacent sides and the two factors of t.
  logic [31:0] d_nxt;
  logic        v1_r;
  logic [31:0] am_r, b1_r, c1_r;
  logic [32:0] ap_r;

  always_comb begin
    d_nxt = (side_b >= side_c) ? (side_b - side_c) : (side_c - side_b);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else if (en) v1_r <= ctl_in.vld;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      am_r <= side_opp - d_nxt;
      ap_r <= {1'b0, side_opp} + {1'b0, d_nxt};
      b1_r <= side_b;
      c1_r <= side_c;
    end
  end

  // Stage 2: partial products of t and the product p = b * c.
  logic        v2_r;
  logic [63:0] tlo_r, p2_r;
  logic [31:0] thi_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else if (en) v2_r <= v1_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tlo_r <= am_r * ap_r[31:0];
      thi_r <= ap_r[32] ? am_r : 32'd0;
      p2_r  <= b1_r * c1_r;
    end
  end

  // Stage 3: t summed from its partial products.
  logic        v3_r;
  logic [63:0] t_r, p3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else if (en) v3_r <= v2_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t_r  <= tlo_r + {thi_r, 32'd0};
      p3_r <= p2_r;
    end
  end

  // Divider: three integer quotient bits, then one fraction bit per stage.
  logic        dv_r [DS];
  logic [63:0] dr_r [DS];
  logic [63:0] dp_r [DS];
  logic [32:0] dq_r [DS];

  for (genvar j = 0; j < DS; j++) begin : g_div
    logic        v_in;
    logic [63:0] r_in, p_in, r_nx;
    logic [32:0] q_in, q_nx;

    if (j == 0) begin : g_first
      assign v_in = v3_r;
      assign r_in = t_r;
      assign p_in = p3_r;
      assign q_in = '0;
    end else begin : g_next
      assign v_in = dv_r[j-1];
      assign r_in = dr_r[j-1];
      assign p_in = dp_r[j-1];
      assign q_in = dq_r[j-1];
    end

    if (j < IS) begin : g_int
      logic [65:0] ps;
      assign ps = {2'b00, p_in} << (IS - 1 - j);
      always_comb begin
        if ({2'b00, r_in} >= ps) begin
          r_nx = r_in - ps[63:0];
          q_nx = {q_in[31:0], 1'b1};
        end else begin
          r_nx = r_in;
          q_nx = {q_in[31:0], 1'b0};
        end
      end
    end else begin : g_frac
      logic [64:0] r2;
      logic [64:0] diff;
      assign r2   = {r_in, 1'b0};
      assign diff = r2 - {1'b0, p_in};
      always_comb begin
        if (r2 >= {1'b0, p_in}) begin
          r_nx = diff[63:0];
          q_nx = {q_in[31:0], 1'b1};
        end else begin
          r_nx = r2[63:0];
          q_nx = {q_in[31:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) dv_r[j] <= 1'b0;
      else if (en) dv_r[j] <= v_in;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dr_r[j] <= r_nx;
        dp_r[j] <= p_in;
        dq_r[j] <= q_nx;
      end
    end
  end

  // Final stage: round the half quotient and form the cosine.
  logic [33:0]        w_full;
  logic signed [34:0] cs_full;
  logic signed [31:0] cs_nxt;
  logic               vc_r;
  logic signed [31:0] cos_r;

  always_comb begin
    w_full  = ({1'b0, dq_r[DS-1]} + 34'd1) >> 1;
    cs_full = $signed({4'b0000, tri_ang_pkg::ONE_Q30}) - $signed({2'b00, w_full[32:0]});
    if (cs_full < -$signed({4'b0000, tri_ang_pkg::ONE_Q30})) begin
      cs_nxt = -$signed({1'b0, tri_ang_pkg::ONE_Q30});
    end else begin
      cs_nxt = cs_full[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vc_r <= 1'b0;
    else if (en) vc_r <= dv_r[DS-1];
  end

  always_ff @(posedge clk) begin
    if (en) cos_r <= cs_nxt;
  end

  assign out_vld = vc_r;
  assign cos_q30 = cos_r;

endmodule

### sv/tri_ang_acos.sv
`timescale 1ns / 1ps
module tri_ang_acos (
  input  logic                      clk,
  input  logic                      rst_n,
  input  tri_ang_pkg::stage_ctl_t   ctl_in,
  input  logic signed [31:0]        cos_q30,
  output logic                      out_vld,
  output logic [31:0]               angle
);

  localparam int SS = tri_ang_pkg::SQRT_STEPS;
  localparam int NC = tri_ang_pkg::CORDIC_STEPS;
  localparam int CW = tri_ang_pkg::CW;

  logic en;
  assign en = ctl_in.en;

  // Stage 1: factors of 1 - x^2, magnitude and sign of x.
  logic signed [32:0] xs;
  logic [32:0]        m1_full, m2_full;
  logic [31:0]        ax_full;
  logic               v1_r, neg1_r, pos1_r;
  logic [31:0]        m1_r, m2_r;
  logic [30:0]        ax1_r;

  always_comb begin
    xs      = {cos_q30[31], cos_q30};
    m1_full = $signed({2'b00, tri_ang_pkg::ONE_Q30}) - xs;
    m2_full = $signed({2'b00, tri_ang_pkg::ONE_Q30}) + xs;
    ax_full = cos_q30[31] ? (32'd0 - cos_q30) : cos_q30;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else if (en) v1_r <= ctl_in.vld;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m1_r   <= m1_full[31:0];
      m2_r   <= m2_full[31:0];
      ax1_r  <= ax_full[30:0];
      neg1_r <= cos_q30[31];
      pos1_r <= !cos_q30[31] && (cos_q30 != 32'sd0);
    end
  end

  // Stage 2: s = (1 - x)(1 + x) in Q4.60.
  logic [63:0] s_full;
  logic        v2_r, neg2_r, pos2_r;
  logic [60:0] s2_r;
  logic [30:0] ax2_r;

  assign s_full = m1_r * m2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else if (en) v2_r <= v1_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_r   <= s_full[60:0];
      ax2_r  <= ax1_r;
      neg2_r <= neg1_r;
      pos2_r <= pos1_r;
    end
  end

  // Square root: one root bit per stage, most significant first.
  logic        sv_r   [SS];
  logic [60:0] srem_r [SS];
  logic [30:0] sroot_r[SS];
  logic [30:0] sax_r  [SS];
  logic        sneg_r [SS];
  logic        spos_r [SS];

  for (genvar k = 0; k < SS; k++) begin : g_sqrt
    localparam int BI = SS - 1 - k;
    logic        v_in, neg_in, pos_in;
    logic [60:0] rem_in, rem_nx;
    logic [30:0] root_in, root_nx, ax_in;
    logic [61:0] trial;

    if (k == 0) begin : g_first
      assign v_in    = v2_r;
      assign rem_in  = s2_r;
      assign root_in = '0;
      assign ax_in   = ax2_r;
      assign neg_in  = neg2_r;
      assign pos_in  = pos2_r;
    end else begin : g_next
      assign v_in    = sv_r[k-1];
      assign rem_in  = srem_r[k-1];
      assign root_in = sroot_r[k-1];
      assign ax_in   = sax_r[k-1];
      assign neg_in  = sneg_r[k-1];
      assign pos_in  = spos_r[k-1];
    end

    assign trial = ({31'd0, root_in} << (BI + 1)) | (62'd1 << (2 * BI));

    always_comb begin
      if (trial <= {1'b0, rem_in}) begin
        rem_nx  = rem_in - trial[60:0];
        root_nx = root_in | (31'd1 << BI);
      end else begin
        rem_nx  = rem_in;
        root_nx = root_in;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) sv_r[k] <= 1'b0;
      else if (en) sv_r[k] <= v_in;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        srem_r[k]  <= rem_nx;
        sroot_r[k] <= root_nx;
        sax_r[k]   <= ax_in;
        sneg_r[k]  <= neg_in;
        spos_r[k]  <= pos_in;
      end
    end
  end

  // CORDIC vectoring on (|x|, y), one rotation per stage.
  logic                 cv_r  [NC];
  logic signed [CW-1:0] cx_r  [NC];
  logic signed [CW-1:0] cy_r  [NC];
  logic signed [CW-1:0] cz_r  [NC];
  logic                 cneg_r[NC];
  logic                 cpos_r[NC];
  logic                 czero_r[NC];

  for (genvar i = 0; i < NC; i++) begin : g_cordic
    logic                 v_in, neg_in, pos_in, zero_in;
    logic signed [CW-1:0] x_in, y_in, z_in, dx, dy, x_nx, y_nx, z_nx, at;

    if (i == 0) begin : g_first
      assign v_in    = sv_r[SS-1];
      assign x_in    = $signed({{(CW-31){1'b0}}, sax_r[SS-1]});
      assign y_in    = $signed({{(CW-31){1'b0}}, sroot_r[SS-1]});
      assign z_in    = '0;
      assign neg_in  = sneg_r[SS-1];
      assign pos_in  = spos_r[SS-1];
      assign zero_in = (sroot_r[SS-1] == 31'd0);
    end else begin : g_next
      assign v_in    = cv_r[i-1];
      assign x_in    = cx_r[i-1];
      assign y_in    = cy_r[i-1];
      assign z_in    = cz_r[i-1];
      assign neg_in  = cneg_r[i-1];
      assign pos_in  = cpos_r[i-1];
      assign zero_in = czero_r[i-1];
    end

    assign dx = y_in >>> i;
    assign dy = x_in >>> i;
    assign at = tri_ang_pkg::atan_q30(5'(i));

    always_comb begin
      if (!y_in[CW-1]) begin
        x_nx = x_in + dx;
        y_nx = y_in - dy;
        z_nx = z_in + at;
      end else begin
        x_nx = x_in - dx;
        y_nx = y_in + dy;
        z_nx = z_in - at;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) cv_r[i] <= 1'b0;
      else if (en) cv_r[i] <= v_in;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        cx_r[i]    <= x_nx;
        cy_r[i]    <= y_nx;
        cz_r[i]    <= z_nx;
        cneg_r[i]  <= neg_in;
        cpos_r[i]  <= pos_in;
        czero_r[i] <= zero_in;
      end
    end
  end

  // Final stage: clamp the angle, fold it for a negative cosine, and give 0 or pi when the root is zero.
  logic signed [CW-1:0] zf;
  logic [31:0]          zc, ang_nxt;
  logic                 va_r;
  logic [31:0]          ang_r;

  always_comb begin
    zf = cz_r[NC-1];
    if (zf[CW-1]) begin
      zc = 32'd0;
    end else if (zf > $signed({2'b00, tri_ang_pkg::HALF_PI_Q30})) begin
      zc = tri_ang_pkg::HALF_PI_Q30;
    end else begin
      zc = zf[31:0];
    end
    if (czero_r[NC-1]) begin
      ang_nxt = cpos_r[NC-1] ? 32'd0 : tri_ang_pkg::PI_Q30;
    end else begin
      ang_nxt = cneg_r[NC-1] ? (tri_ang_pkg::PI_Q30 - zc) : zc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) va_r <= 1'b0;
    else if (en) va_r <= cv_r[NC-1];
  end

  always_ff @(posedge clk) begin
    if (en) ang_r <= ang_nxt;
  end

  assign out_vld = va_r;
  assign angle   = ang_r;

endmodule

### sv/tri_ang_lane.sv
`timescale 1ns / 1ps
module tri_ang_lane (
  input  logic                      clk,
  input  logic                      rst_n,
  input  tri_ang_pkg::stage_ctl_t   ctl_in,
  input  logic [31:0]               side_opp,
  input  logic [31:0]               side_b,
  input  logic [31:0]               side_c,
  output logic                      out_vld,
  output logic [31:0]               angle
);

  // Cosine of the angle opposite side_opp, then its arccosine.
  logic                    cos_vld;
  logic signed [31:0]      cos_q30;
  tri_ang_pkg::stage_ctl_t acos_ctl;

  tri_ang_cos u_cos (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl_in   (ctl_in),
    .side_opp (side_opp),
    .side_b   (side_b),
    .side_c   (side_c),
    .out_vld  (cos_vld),
    .cos_q30  (cos_q30)
  );

  assign acos_ctl.vld = cos_vld;
  assign acos_ctl.en  = ctl_in.en;

  tri_ang_acos u_acos (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl_in  (acos_ctl),
    .cos_q30 (cos_q30),
    .out_vld (out_vld),
    .angle   (angle)
  );

endmodule

### tb/sv/tb_triangle_angles_from_sides.sv
`timescale 1ns / 1ps
module tb_triangle_angles_from_sides;

  // One triangle result: three angles and the reject flag.
  typedef struct packed {
    logic [31:0] ang_ab;
    logic [31:0] ang_bc;
    logic [31:0] ang_ca;
    logic        bad;
  } tri_angles_t;

  // Arithmetic shift right with floor semantics.
  function automatic longint floor_shr(input longint v, input int s);
    return v >>> s;
  endfunction

  // Integer square root of a 64-bit value.
  function automatic logic [63:0] int_sqrt(input logic [63:0] v);
    logic [63:0] res, bit_w;
    res = 0;
    bit_w = 64'd1 << 62;
    while (bit_w > v) bit_w = bit_w >> 2;
    while (bit_w != 0) begin
      if (v >= res + bit_w) begin
        v = v - (res + bit_w);
        res = (res >> 1) + bit_w;
      end else begin
        res = res >> 1;
      end
      bit_w = bit_w >> 2;
    end
    return res;
  endfunction

  // Arccosine of a Q1.30 cosine by root and CORDIC vectoring.
  function automatic longint arccos_q30(input longint x);
    longint ax, cx, cy, z, dx, dy, one;
    logic [63:0] s;
    one = 64'd1 << 30;
    ax = x < 0 ? -x : x;
    s = (one - x) * (one + x);
    cy = longint'(int_sqrt(s));
    if (cy == 0) return x > 0 ? 64'sd0 : longint'(tri_ang_pkg::PI_Q30);
    cx = ax;
    z = 0;
    for (int i = 0; i < tri_ang_pkg::CORDIC_STEPS; i++) begin
      dx = floor_shr(cy, i);
      dy = floor_shr(cx, i);
      if (cy >= 0) begin
        cx += dx; cy -= dy; z += longint'(tri_ang_pkg::atan_q30(i[4:0]));
      end else begin
        cx -= dx; cy += dy; z -= longint'(tri_ang_pkg::atan_q30(i[4:0]));
      end
    end
    if (z < 0) z = 0;
    if (z > longint'(tri_ang_pkg::HALF_PI_Q30)) z = longint'(tri_ang_pkg::HALF_PI_Q30);
    return x < 0 ? longint'(tri_ang_pkg::PI_Q30) - z : z;
  endfunction

  // Angle opposite side a by the law of cosines.
  function automatic logic [31:0] angle_opp(input logic [63:0] a, b, c);
    logic [63:0] d, t, p, w;
    logic [127:0] q;
    longint cs, one;
    one = 64'd1 << 30;
    d = b >= c ? b - c : c - b;
    t = (a - d) * (a + d);
    p = b * c;
    q = ({64'd0, t} << 30) / {64'd0, p};
    w = (q[63:0] + 64'd1) >> 1;
    cs = one - longint'(w > 64'hFFFF_FFFF ? 64'hFFFF_FFFF : w);
    if (cs < -one) cs = -one;
    if (cs > one) cs = one;
    return 32'(arccos_q30(cs));
  endfunction

  function automatic tri_angles_t solve_triangle(input logic [31:0] sa, sb, sc);
    tri_angles_t r;
    logic [63:0] a, b, c;
    a = {32'd0, sa}; b = {32'd0, sb}; c = {32'd0, sc};
    r = '0;
    if (a == 0 || b == 0 || c == 0 || a > b + c || b > a + c || c > a + b) begin
      r.bad = 1'b1;
    end else begin
      r.ang_ab = angle_opp(a, b, c);
      r.ang_bc = angle_opp(b, a, c);
      r.ang_ca = angle_opp(c, a, b);
    end
    return r;
  endfunction

  // Scoreboard of expected triangle results.
  class angle_board;
    tri_angles_t pending[$];
    int mismatches, checked, bad_seen;
    function void note_sides(input logic [31:0] sa, sb, sc);
      pending.insert(pending.size(), solve_triangle(sa, sb, sc));
    endfunction
    function void check_angles(input tri_angles_t got);
      tri_angles_t exp_r;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
        return;
      end
      exp_r = pending.pop_front();
      checked++;
      if (exp_r.bad) bad_seen++;
      if (exp_r != got) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp ab=%h bc=%h ca=%h bad=%b got ab=%h bc=%h ca=%h bad=%b",
                   exp_r.ang_ab, exp_r.ang_bc, exp_r.ang_ca, exp_r.bad,
                   got.ang_ab, got.ang_bc, got.ang_ca, got.bad);
      end
    endfunction
  endclass

  logic clk = 0, rst_n = 0;
  logic in_valid = 0, out_ready = 0;
  logic [31:0] in_side_ab = 0, in_side_bc = 0, in_side_ca = 0;
  logic in_ready, out_valid, out_bad_triangle;
  logic [31:0] out_angle_opp_ab, out_angle_opp_bc, out_angle_opp_ca;
  angle_board board = new();
  bit sending_done = 0, long_hold = 0;
  int sent = 0;

  triangle_angles_from_sides uut (.*);

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  // Runaway guard.
  initial begin
    #20ms;
    $display("tb_triangle_angles_from_sides NOT OK");
    $finish;
  end

  // Offer one triangle and wait for it to be taken.
  task automatic send_sides(input logic [31:0] sa, sb, sc);
    int gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1; in_side_ab <= sa; in_side_bc <= sb; in_side_ca <= sc;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_sides(sa, sb, sc);
    sent++;
  endtask

  function automatic logic [31:0] rand_side();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return $urandom_range(1, 16);
      2: return 32'hFFFF_FFFF - $urandom_range(0, 3);
      default: return $urandom_range(32'h0001_0000, 32'h0100_0000);
    endcase
  endfunction

  // Stimulus: directed corners, then random triangles mostly valid.
  initial begin
    logic [31:0] a, b, c;
    repeat (12) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    send_sides(0, 5, 5);
    send_sides(5, 0, 5);
    send_sides(5, 5, 0);
    send_sides(0, 0, 0);
    send_sides(32'h10000, 32'h10000, 32'h10000);
    send_sides(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_sides(1, 1, 1);
    send_sides(2, 1, 1);
    send_sides(1, 2, 1);
    send_sides(1, 1, 2);
    send_sides(3, 1, 1);
    send_sides(32'h30000, 32'h40000, 32'h50000);
    send_sides(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
    send_sides(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_sides(32'hFFFF_FFFF, 1, 32'hFFFF_FFFF);
    send_sides(32'h8000_0000, 32'h8000_0000, 1);
    send_sides(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA);
    for (int n = 0; n < 600; n++) begin
      a = rand_side(); b = rand_side();
      case ($urandom_range(0, 9))
        0: c = a + b;
        1: c = rand_side();
        2: c = $urandom_range(0, 1) ? a + b + 1 : 0;
        default: begin
          c = (a > b ? a - b : b - a) + $urandom_range(0, 1 << 20);
          if (c == 0) c = 1;
        end
      endcase
      if ({32'd0, a} + b > 64'hFFFF_FFFF && $urandom_range(0, 1)) c = a;
      if (n == 200) long_hold = 1;
      send_sides(a, b, c);
    end
    in_valid <= 0;
    sending_done = 1;
  end

  // Receiver with random stalls and one long hold-off.
  initial begin
    tri_angles_t got;
    int wait_n;
    out_ready <= 0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        got = {out_angle_opp_ab, out_angle_opp_bc, out_angle_opp_ca, out_bad_triangle};
        board.check_angles(got);
      end
      if (long_hold) begin
        long_hold = 0;
        out_ready <= 0;
        repeat (400) @(posedge clk);
      end
      wait_n = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 12);
      if (wait_n == 0) out_ready <= 1;
      else begin
        out_ready <= 0;
        repeat (wait_n) @(posedge clk);
        out_ready <= 1;
      end
    end
  end

  // End of run.
  initial begin
    wait (sending_done);
    while (board.pending.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
    $display("Checked %0d triangles, %0d of them rejected, with stalls on both sides.",
             board.checked, board.bad_seen);
    if (board.mismatches == 0 && board.pending.size() == 0)
      $display("tb_triangle_angles_from_sides OK");
    else
      $display("tb_triangle_angles_from_sides NOT OK");
    $finish;
  end

endmodule
